// ----- rtl/glyph_atlas_cache_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Glyph atlas cache allocator - assertion macros
// Shared property wrappers, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_CACHE_ALLOCATOR_UNIT_DEFINES_SVH
`define GLYPH_ATLAS_CACHE_ALLOCATOR_UNIT_DEFINES_SVH

// Condition holds at every edge.
`define GAAC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define GAAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GAAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gaac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas cache allocator - package
// Shared constants, result codes and table entry layout.
// ----------------------------------------------------------------------------
package gaac_pkg;

  localparam int unsigned ENTRIES_DEF   = 256;
  localparam int unsigned ATLAS_MAX_DEF = 4096;
  localparam int unsigned GLYPH_MAX_DEF = 255;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SLOT_XY_W = 12;
  localparam int unsigned GLYPH_W   = 8;
  localparam int unsigned KEY_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] ATLAS_SIZE_RST = 13'd512;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_PLACED  = 2'd1,
    ST_NOROOM  = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  typedef struct packed {
    logic [SLOT_XY_W-1:0] x;
    logic [SLOT_XY_W-1:0] y;
    logic [GLYPH_W-1:0]   w;
    logic [GLYPH_W-1:0]   h;
  } slot_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    slot_t            slot;
  } entry_t;

  typedef struct packed {
    status_e status;
    slot_t   slot;
  } res_t;

endpackage

// ----- rtl/glyph_atlas_cache_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas cache allocator
// Glyph cache with shelf packing of glyph slots into a texture atlas.
// ----------------------------------------------------------------------------
// One item at a time. A clear goes from acceptance straight to the response
// state. A place request scans the filled part of the entry table through
// its single read port, one entry per cycle; a hit ends the scan early and a
// miss reads all N stored glyphs (up to ENTRIES). The placement steps after
// the scan all run through one shared adder and compare unit. The table has
// no clearing pass: a fill count marks the valid entries, so a clear is
// immediate. The result sits in an output register, and the next item is
// taken while it waits.
module glyph_atlas_cache_allocator_unit #(
  parameter int unsigned ENTRIES   = gaac_pkg::ENTRIES_DEF,
  parameter int unsigned ATLAS_MAX = gaac_pkg::ATLAS_MAX_DEF,
  parameter int unsigned GLYPH_MAX = gaac_pkg::GLYPH_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gaac_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gaac_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [15:0]                      font_id_i,
  input  logic [15:0]                      glyph_index_i,
  input  logic [gaac_pkg::GLYPH_W-1:0]     glyph_width_i,
  input  logic [gaac_pkg::GLYPH_W-1:0]     glyph_height_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [gaac_pkg::SLOT_XY_W-1:0]   slot_x_o,
  output logic [gaac_pkg::SLOT_XY_W-1:0]   slot_y_o,
  output logic [gaac_pkg::GLYPH_W-1:0]     slot_width_o,
  output logic [gaac_pkg::GLYPH_W-1:0]     slot_height_o
);

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned CNTW = $clog2(ENTRIES + 1);
  localparam int unsigned CW   = $clog2(ATLAS_MAX + 512);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_FIT_X  = 8'b0000_0100,
    S_NEWROW = 8'b0000_1000,
    S_FIT_X2 = 8'b0001_0000,
    S_FIT_Y  = 8'b0010_0000,
    S_COMMIT = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_e;

  localparam gaac_pkg::res_t RES_NOROOM  = '{status: gaac_pkg::ST_NOROOM, slot: '0};
  localparam gaac_pkg::res_t RES_CLEARED = '{status: gaac_pkg::ST_CLEARED, slot: '0};

  state_e state_q, state_d;

  // control state
  logic [gaac_pkg::CFG_W-1:0] atlas_w_q, atlas_h_q;
  logic [CNTW-1:0]            count_q;
  logic [CW-1:0]              cur_x_q, cur_y_q;
  logic [gaac_pkg::GLYPH_W-1:0] row_h_q;
  logic [CNTW-1:0]            idx_q;
  logic                       rvalid_q;
  logic                       out_valid_q;

  // item payload and working copies
  logic [gaac_pkg::KEY_W-1:0]   key_q;
  logic [gaac_pkg::GLYPH_W-1:0] gw_q, gh_q, rh_q;
  logic [CW-1:0]                x_q, y_q;
  gaac_pkg::res_t               res_q, out_q;

  logic                       accept;
  logic                       issue;
  logic                       hit;
  logic                       too_big;
  logic                       can_load;
  logic [CW-1:0]              aw_lim, ah_lim;
  logic [gaac_pkg::GLYPH_W-1:0] wt, ht;
  logic [CW-1:0]              alu_a, alu_b, alu_lim, alu_sum;
  logic                       alu_cin, alu_gt;
  gaac_pkg::entry_t           rd_entry, wr_entry;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign issue    = (state_q == S_SCAN) && (idx_q < count_q);
  assign hit      = rvalid_q && (rd_entry.key == key_q);
  assign can_load = !out_valid_q || !out_stall_i;

  assign aw_lim = (int'(atlas_w_q) > ATLAS_MAX) ? CW'(ATLAS_MAX) : CW'(atlas_w_q);
  assign ah_lim = (int'(atlas_h_q) > ATLAS_MAX) ? CW'(ATLAS_MAX) : CW'(atlas_h_q);

  // zero-sized glyphs count as one pixel for the edge tests
  assign wt = (gw_q == '0) ? gaac_pkg::GLYPH_W'(1) : gw_q;
  assign ht = (gh_q == '0) ? gaac_pkg::GLYPH_W'(1) : gh_q;

  assign too_big = (int'(gw_q) > GLYPH_MAX) || (int'(gh_q) > GLYPH_MAX) ||
                   (int'(count_q) >= ENTRIES);

  assign wr_entry = '{key:  key_q,
                      slot: '{x: gaac_pkg::SLOT_XY_W'(x_q),
                              y: gaac_pkg::SLOT_XY_W'(y_q),
                              w: gw_q,
                              h: gh_q}};

  gaac_mem #(
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (state_q == S_COMMIT),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (issue),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (rd_entry)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    alu_lim = aw_lim;
    unique case (state_q)
      S_FIT_X: begin
        alu_a = x_q;
        alu_b = CW'(wt);
      end
      S_NEWROW: begin
        alu_a   = y_q;
        alu_b   = CW'(rh_q);
        alu_cin = 1'b1;
        alu_lim = ah_lim;
      end
      S_FIT_X2: begin
        alu_b = CW'(wt);
      end
      S_FIT_Y: begin
        alu_a   = y_q;
        alu_b   = CW'(ht);
        alu_lim = ah_lim;
      end
      S_COMMIT: begin
        alu_a   = x_q;
        alu_b   = CW'(gw_q);
        alu_cin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  gaac_alu #(
    .CW (CW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .cin_i (alu_cin),
    .lim_i (alu_lim),
    .sum_o (alu_sum),
    .gt_o  (alu_gt)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = req_type_i ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_RESP;
        end else if (!issue && !rvalid_q) begin
          state_d = S_FIT_X;
        end
      end
      S_FIT_X: begin
        if (too_big) begin
          state_d = S_RESP;
        end else begin
          state_d = alu_gt ? S_NEWROW : S_FIT_Y;
        end
      end
      S_NEWROW: state_d = S_FIT_X2;
      S_FIT_X2: state_d = alu_gt ? S_RESP : S_FIT_Y;
      S_FIT_Y:  state_d = alu_gt ? S_RESP : S_COMMIT;
      S_COMMIT: state_d = S_RESP;
      S_RESP: begin
        if (can_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      atlas_w_q   <= gaac_pkg::ATLAS_SIZE_RST;
      atlas_h_q   <= gaac_pkg::ATLAS_SIZE_RST;
      count_q     <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      row_h_q     <= '0;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        if (cfg_index_i == gaac_pkg::CFG_ATLAS_WIDTH) begin
          atlas_w_q <= cfg_data_i;
        end else if (cfg_index_i == gaac_pkg::CFG_ATLAS_HEIGHT) begin
          atlas_h_q <= cfg_data_i;
        end
      end

      if (accept) begin
        idx_q    <= '0;
        rvalid_q <= 1'b0;
        if (req_type_i) begin
          count_q <= '0;
          cur_x_q <= '0;
          cur_y_q <= '0;
          row_h_q <= '0;
        end
      end

      // one read issued and one compared per cycle
      if (state_q == S_SCAN) begin
        if (hit) begin
          rvalid_q <= 1'b0;
        end else begin
          idx_q    <= idx_q + CNTW'(issue);
          rvalid_q <= issue;
        end
      end

      if (state_q == S_COMMIT) begin
        count_q <= count_q + CNTW'(1);
        cur_x_q <= alu_sum;
        cur_y_q <= y_q;
        row_h_q <= (rh_q < gh_q) ? gh_q : rh_q;
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == S_RESP) && can_load) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= {font_id_i, glyph_index_i};
      gw_q  <= glyph_width_i;
      gh_q  <= glyph_height_i;
      x_q   <= cur_x_q;
      y_q   <= cur_y_q;
      rh_q  <= row_h_q;
      if (req_type_i) begin
        res_q <= RES_CLEARED;
      end
    end

    unique case (state_q)
      S_SCAN: begin
        if (hit) begin
          res_q <= '{status: gaac_pkg::ST_HIT, slot: rd_entry.slot};
        end
      end
      S_FIT_X: begin
        if (too_big) begin
          res_q <= RES_NOROOM;
        end
      end
      S_NEWROW: begin
        // open a new row one pixel below the tallest glyph
        x_q  <= '0;
        y_q  <= alu_sum;
        rh_q <= '0;
      end
      S_FIT_X2, S_FIT_Y: begin
        if (alu_gt) begin
          res_q <= RES_NOROOM;
        end
      end
      S_COMMIT: begin
        res_q <= '{status: gaac_pkg::ST_PLACED, slot: wr_entry.slot};
      end
      S_RESP: begin
        if (can_load) begin
          out_q <= res_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign slot_x_o      = out_q.slot.x;
  assign slot_y_o      = out_q.slot.y;
  assign slot_width_o  = out_q.slot.w;
  assign slot_height_o = out_q.slot.h;

`include "glyph_atlas_cache_allocator_unit_defines.svh"

  `GAAC_ASSERT_ALWAYS(a_count_max, int'(count_q) <= ENTRIES, "entry count beyond table depth")
  `GAAC_ASSERT_NXT(a_commit_count, state_q == S_COMMIT, count_q == $past(count_q) + CNTW'(1), "placement did not advance entry count")
  `GAAC_ASSERT_IMP(a_clear_empties, (state_q == S_RESP) && (res_q.status == gaac_pkg::ST_CLEARED), (count_q == '0) && (cur_x_q == '0) && (cur_y_q == '0), "clear left entries or cursors")
  `GAAC_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, idx_q <= count_q, "scan index ran past fill count")

endmodule

// ----- rtl/gaac_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas cache allocator - entry table
// One write port and one registered read port holding key and slot per entry.
// ----------------------------------------------------------------------------
module gaac_mem #(
  parameter int unsigned ENTRIES = gaac_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  gaac_pkg::entry_t           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output gaac_pkg::entry_t           rdata_o
);

  gaac_pkg::entry_t mem_q [ENTRIES];
  gaac_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gaac_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas cache allocator - shared add and compare unit
// Forms a + b + carry and flags when the sum passes the given limit.
// ----------------------------------------------------------------------------
module gaac_alu #(
  parameter int unsigned CW = 13
) (
  input  logic [CW-1:0] a_i,
  input  logic [CW-1:0] b_i,
  input  logic          cin_i,
  input  logic [CW-1:0] lim_i,
  output logic [CW-1:0] sum_o,
  output logic          gt_o
);

  logic [CW:0] sum_full;

  assign sum_full = {1'b0, a_i} + {1'b0, b_i} + {{CW{1'b0}}, cin_i};
  assign sum_o    = sum_full[CW-1:0];
  assign gt_o     = sum_full > {1'b0, lim_i};

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas cache allocator - testbench
// Drives place and clear requests through the valid/stall handshake while a
// built-in model of the shelf packer and glyph table predicts every result.
// A monitor compares each result field by field with the oldest prediction.
// It covers directed edge cases, a full table, random traffic under several
// atlas sizes and idling patterns, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CFG_W     = gaac_pkg::CFG_W;
  localparam int unsigned CFG_IDX_W = gaac_pkg::CFG_IDX_W;
  localparam int unsigned GLYPH_W   = gaac_pkg::GLYPH_W;
  localparam int unsigned SLOT_XY_W = gaac_pkg::SLOT_XY_W;
  localparam int unsigned KEY_W     = gaac_pkg::KEY_W;

  localparam logic REQ_PLACE = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic [CFG_W-1:0] SIZE_ALL_ONES = 13'h1FFF;

  localparam int unsigned RX_HOLD_CYCLES = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 req_type_i;
  logic [15:0]          font_id_i;
  logic [15:0]          glyph_index_i;
  logic [GLYPH_W-1:0]   glyph_width_i;
  logic [GLYPH_W-1:0]   glyph_height_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           status_o;
  logic [SLOT_XY_W-1:0] slot_x_o;
  logic [SLOT_XY_W-1:0] slot_y_o;
  logic [GLYPH_W-1:0]   slot_width_o;
  logic [GLYPH_W-1:0]   slot_height_o;

  glyph_atlas_cache_allocator_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .font_id_i      (font_id_i),
    .glyph_index_i  (glyph_index_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_x_o       (slot_x_o),
    .slot_y_o       (slot_y_o),
    .slot_width_o   (slot_width_o),
    .slot_height_o  (slot_height_o)
  );

  // Packer model state
  logic [KEY_W-1:0] glyph_keys  [gaac_pkg::ENTRIES_DEF];
  gaac_pkg::slot_t  glyph_slots [gaac_pkg::ENTRIES_DEF];
  int unsigned      glyph_count;
  int unsigned      pen_x;
  int unsigned      pen_y;
  int unsigned      shelf_height;
  logic [CFG_W-1:0] atlas_w_reg;
  logic [CFG_W-1:0] atlas_h_reg;

  gaac_pkg::res_t expected_placements [$];
  int unsigned    mismatch_count = 0;
  int unsigned    tx_idle_pct;
  int unsigned    rx_stall_pct;
  int unsigned    rx_hold_requests;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic gaac_pkg::res_t predict_placement(input logic req,
                                                       input logic [15:0] font,
                                                       input logic [15:0] gidx,
                                                       input logic [7:0] gw,
                                                       input logic [7:0] gh);
    gaac_pkg::res_t   r;
    logic [KEY_W-1:0] key;
    int unsigned      aw, ah, wt, ht, x, y, rh, i;
    r = '0;
    if (req == REQ_CLEAR) begin
      glyph_count  = 0;
      pen_x        = 0;
      pen_y        = 0;
      shelf_height = 0;
      r.status     = gaac_pkg::ST_CLEARED;
      return r;
    end
    key = {font, gidx};
    for (i = 0; i < glyph_count; i++) begin
      if (glyph_keys[i] == key) begin
        r.status = gaac_pkg::ST_HIT;
        r.slot   = glyph_slots[i];
        return r;
      end
    end
    r.status = gaac_pkg::ST_NOROOM;
    if (gw > gaac_pkg::GLYPH_MAX_DEF || gh > gaac_pkg::GLYPH_MAX_DEF ||
        glyph_count >= gaac_pkg::ENTRIES_DEF) return r;
    aw = (atlas_w_reg > gaac_pkg::ATLAS_MAX_DEF) ? gaac_pkg::ATLAS_MAX_DEF : atlas_w_reg;
    ah = (atlas_h_reg > gaac_pkg::ATLAS_MAX_DEF) ? gaac_pkg::ATLAS_MAX_DEF : atlas_h_reg;
    // an empty glyph still needs one pixel inside the atlas
    wt = (gw == 0) ? 1 : gw;
    ht = (gh == 0) ? 1 : gh;
    x  = pen_x;
    y  = pen_y;
    rh = shelf_height;
    if (x + wt > aw) begin
      x  = 0;
      y  = y + rh + 1;
      rh = 0;
    end
    // leave the cursors alone on failure, even after a tentative new shelf
    if (x + wt > aw || y + ht > ah) return r;
    r.status = gaac_pkg::ST_PLACED;
    r.slot.x = x[SLOT_XY_W-1:0];
    r.slot.y = y[SLOT_XY_W-1:0];
    r.slot.w = gw;
    r.slot.h = gh;
    glyph_keys[glyph_count]  = key;
    glyph_slots[glyph_count] = r.slot;
    glyph_count++;
    pen_x        = x + gw + 1;
    pen_y        = y;
    shelf_height = (rh < gh) ? gh : rh;
    return r;
  endfunction

  task automatic send_item(input logic req, input logic [15:0] font, input logic [15:0] gidx,
                           input logic [7:0] gw, input logic [7:0] gh);
    gaac_pkg::res_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    font_id_i      <= font;
    glyph_index_i  <= gidx;
    glyph_width_i  <= gw;
    glyph_height_i <= gh;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted           = predict_placement(req, font, gidx, gw, gh);
    expected_placements = {expected_placements, predicted};
  endtask

  task automatic send_random_item();
    logic        req;
    logic [15:0] font;
    logic [15:0] gidx;
    logic [7:0]  gw;
    logic [7:0]  gh;
    req = ($urandom_range(99) < 3) ? REQ_CLEAR : REQ_PLACE;
    if ($urandom_range(9) == 0) begin
      font = 16'($urandom);
      gidx = 16'($urandom);
    end else begin
      // small key pool so that lookups hit often
      case ($urandom_range(3))
        0:       font = 16'h0000;
        1:       font = 16'hFFFF;
        2:       font = 16'h00A5;
        default: font = 16'h5A00;
      endcase
      gidx = 16'($urandom_range(47));
    end
    gw = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(24));
    gh = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(24));
    send_item(req, font, gidx, gw, gh);
  endtask

  // Drop valid and hold until every predicted result has been seen
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      gaac_pkg::CFG_ATLAS_WIDTH:  atlas_w_reg = data;
      gaac_pkg::CFG_ATLAS_HEIGHT: atlas_h_reg = data;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_item(REQ_PLACE, 16'h0000, 16'h0000, 8'd0,   8'd0);
    send_item(REQ_PLACE, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
    // lands exactly on the right edge
    send_item(REQ_PLACE, 16'h5555, 16'hAAAA, 8'd255, 8'd1);
    send_item(REQ_PLACE, 16'h0000, 16'h0000, 8'd7,   8'd9);
    send_item(REQ_PLACE, 16'hFFFF, 16'hFFFF, 8'd0,   8'd0);
    send_item(REQ_PLACE, 16'hAAAA, 16'h5555, 8'd0,   8'd0);
    send_item(REQ_PLACE, 16'h0001, 16'h0002, 8'd10,  8'd255);
    send_item(REQ_PLACE, 16'h0001, 16'h0003, 8'd255, 8'd10);
    // new shelf falls off the bottom, then the old shelf must still be usable
    send_item(REQ_PLACE, 16'h0001, 16'h0004, 8'd255, 8'd1);
    send_item(REQ_PLACE, 16'h0001, 16'h0005, 8'd200, 8'd5);
    send_item(REQ_CLEAR, 16'h0000, 16'h0000, 8'd0,   8'd0);
    send_item(REQ_PLACE, 16'h0000, 16'h0000, 8'd3,   8'd4);
    drain_results();
    write_reg(gaac_pkg::CFG_ATLAS_WIDTH, '0);
    send_item(REQ_PLACE, 16'h0002, 16'h0000, 8'd1,   8'd1);
    send_item(REQ_PLACE, 16'h0000, 16'h0000, 8'd1,   8'd1);
    drain_results();
    write_reg(gaac_pkg::CFG_ATLAS_WIDTH, SIZE_ALL_ONES);
    write_reg(gaac_pkg::CFG_ATLAS_HEIGHT, 13'd1);
    send_item(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
    send_item(REQ_PLACE, 16'h0003, 16'h0000, 8'd0,   8'd0);
    send_item(REQ_PLACE, 16'h0003, 16'h0001, 8'd255, 8'd1);
    send_item(REQ_PLACE, 16'h0003, 16'h0002, 8'd1,   8'd2);
    drain_results();
    // spare indexes must not disturb the size registers
    write_reg(CFG_SPARE_2, SIZE_ALL_ONES);
    write_reg(CFG_SPARE_3, '0);
    write_reg(gaac_pkg::CFG_ATLAS_WIDTH, 13'd10);
    write_reg(gaac_pkg::CFG_ATLAS_HEIGHT, 13'd4096);
    send_item(REQ_CLEAR, 16'h0000, 16'h0000, 8'd0,   8'd0);
    send_item(REQ_PLACE, 16'h0004, 16'h0000, 8'd4,   8'd3);
    send_item(REQ_PLACE, 16'h0004, 16'h0001, 8'd5,   8'd0);
    send_item(REQ_PLACE, 16'h0004, 16'h0002, 8'd1,   8'd1);
    send_item(REQ_PLACE, 16'h0004, 16'h0003, 8'd11,  8'd1);
    drain_results();
    write_reg(gaac_pkg::CFG_ATLAS_WIDTH, 13'd1);
    send_item(REQ_PLACE, 16'h0004, 16'h0004, 8'd0,   8'd7);
    drain_results();
  endtask

  task automatic test_full_table();
    int unsigned i;
    tx_idle_pct  = 15;
    rx_stall_pct = 15;
    write_reg(gaac_pkg::CFG_ATLAS_WIDTH, 13'd4096);
    write_reg(gaac_pkg::CFG_ATLAS_HEIGHT, SIZE_ALL_ONES);
    send_item(REQ_CLEAR, 16'h0000, 16'h0000, 8'd0, 8'd0);
    for (i = 0; i < gaac_pkg::ENTRIES_DEF; i++) begin
      send_item(REQ_PLACE, 16'hC0DE, i[15:0], 8'($urandom_range(7)), 8'($urandom_range(7)));
    end
    // table full: a miss gets no room, lookups still hit
    send_item(REQ_PLACE, 16'hC0DE, 16'hFFFF, 8'd1, 8'd1);
    send_item(REQ_PLACE, 16'hC0DE, 16'h0000, 8'd1, 8'd1);
    send_item(REQ_PLACE, 16'hC0DE, 16'(gaac_pkg::ENTRIES_DEF - 1), 8'd1, 8'd1);
    send_item(REQ_PLACE, 16'hC0DE, 16'($urandom_range(gaac_pkg::ENTRIES_DEF - 1)),
              8'd9, 8'd9);
    send_item(REQ_CLEAR, 16'h0000, 16'h0000, 8'd0, 8'd0);
    send_item(REQ_PLACE, 16'hC0DE, 16'hFFFF, 8'd1, 8'd1);
    drain_results();
  endtask

  task automatic test_random_phases();
    int unsigned phase;
    int unsigned n;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          write_reg(gaac_pkg::CFG_ATLAS_WIDTH, 13'd512);
          write_reg(gaac_pkg::CFG_ATLAS_HEIGHT, 13'd512);
        end
        1: begin
          tx_idle_pct  = 83;
          rx_stall_pct = 0;
          write_reg(gaac_pkg::CFG_ATLAS_WIDTH, SIZE_ALL_ONES);
          write_reg(gaac_pkg::CFG_ATLAS_HEIGHT, 13'd300);
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 83;
          write_reg(gaac_pkg::CFG_ATLAS_WIDTH, CFG_W'($urandom_range(400, 16)));
          write_reg(gaac_pkg::CFG_ATLAS_HEIGHT, CFG_W'($urandom_range(400, 16)));
        end
        default: begin
          tx_idle_pct  = 15;
          rx_stall_pct = 15;
          write_reg(gaac_pkg::CFG_ATLAS_WIDTH, 13'd4096);
          write_reg(gaac_pkg::CFG_ATLAS_HEIGHT, 13'd4096);
        end
      endcase
      send_item(REQ_CLEAR, 16'h0000, 16'h0000, 8'd0, 8'd0);
      for (n = 0; n < 30; n++) send_random_item();
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    int unsigned n;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_reg(gaac_pkg::CFG_ATLAS_WIDTH, 13'd512);
    write_reg(gaac_pkg::CFG_ATLAS_HEIGHT, 13'd512);
    // long output hold-off while items keep coming, so the input stalls
    rx_hold_requests++;
    for (n = 0; n < 24; n++) send_random_item();
    drain_results();
    tx_idle_pct  = 83;
    rx_stall_pct = 83;
    for (n = 0; n < 8; n++) send_random_item();
    drain_results();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (holds_served != rx_hold_requests) begin
        out_stall_i <= 1'b1;
        hold_left    = RX_HOLD_CYCLES - 1;
        holds_served++;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    gaac_pkg::res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_placements.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result status %0d slot (%0d,%0d) %0dx%0d", $realtime,
                   status_o, slot_x_o, slot_y_o, slot_width_o, slot_height_o);
      end else begin
        exp_res = expected_placements.pop_front();
        if (status_o !== exp_res.status || slot_x_o !== exp_res.slot.x ||
            slot_y_o !== exp_res.slot.y || slot_width_o !== exp_res.slot.w ||
            slot_height_o !== exp_res.slot.h) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch expected status %0d slot (%0d,%0d) %0dx%0d, got %0d (%0d,%0d) %0dx%0d",
                     $realtime, exp_res.status, exp_res.slot.x, exp_res.slot.y,
                     exp_res.slot.w, exp_res.slot.h, status_o, slot_x_o, slot_y_o,
                     slot_width_o, slot_height_o);
        end
      end
    end
  end

  initial begin
    #30000000;
    $display("** glyph_atlas_cache_allocator_unit: FAILED **");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    req_type_i       = REQ_PLACE;
    font_id_i        = '0;
    glyph_index_i    = '0;
    glyph_width_i    = '0;
    glyph_height_i   = '0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    rx_hold_requests = 0;
    atlas_w_reg      = gaac_pkg::ATLAS_SIZE_RST;
    atlas_h_reg      = gaac_pkg::ATLAS_SIZE_RST;
    glyph_count      = 0;
    pen_x            = 0;
    pen_y            = 0;
    shelf_height     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_random_phases();
    test_backpressure();

    drain_results();
    repeat (gaac_pkg::ENTRIES_DEF + 16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_placements.size() == 0) begin
      $display("** glyph_atlas_cache_allocator_unit: PASSED **");
    end else begin
      $display("** glyph_atlas_cache_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
